// ===== rtl/palette_linear_fade_defines.svh =====
// ---------------------------------------------------------------------------
// palette fade assertion macros
// shared property templates for the checker of the palette fade block
// ---------------------------------------------------------------------------
`ifndef PALETTE_LINEAR_FADE_DEFINES_SVH
`define PALETTE_LINEAR_FADE_DEFINES_SVH

// implication checked in the same cycle, off during reset
`define PLF_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// implication checked in the next cycle, off during reset
`define PLF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

// condition that must hold in the cycle after reset is seen low
`define PLF_ASSERT_IN_RESET(lbl, clk, rst_n, cons, msg) \
  lbl: assert property (@(posedge clk) !(rst_n) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/plf_pkg.sv =====
// ---------------------------------------------------------------------------
// palette fade package
// shared types and constants of the palette fade block
// ---------------------------------------------------------------------------
package plf_pkg;

  localparam int COLOR_W = 8;
  localparam int INDEX_W = 8;
  localparam int STEPS_W = 10;
  localparam logic [STEPS_W-1:0] STEPS_RESET = 10'd64;

  // request command codes
  typedef enum logic {
    CMD_INIT = 1'b0,
    CMD_STEP = 1'b1
  } plf_cmd_e;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_READ,
    ST_FINISH
  } plf_state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic div_step;
    logic mem_read;
    logic commit;
  } plf_ctrl_t;

  // status from datapath to controller, decoded from the incoming request
  typedef struct packed {
    logic is_step;
    logic in_range;
  } plf_stat_t;

endpackage

// ===== rtl/plf_if.sv =====
// ---------------------------------------------------------------------------
// palette fade channels
// request and response channels with valid/ready handshake
// ---------------------------------------------------------------------------
interface plf_req_if import plf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               cmd;
  logic [INDEX_W-1:0] index;
  logic [COLOR_W-1:0] target_red;
  logic [COLOR_W-1:0] target_green;
  logic [COLOR_W-1:0] target_blue;
  logic [COLOR_W-1:0] start_red;
  logic [COLOR_W-1:0] start_green;
  logic [COLOR_W-1:0] start_blue;

  modport source (
    output valid, cmd, index, target_red, target_green, target_blue,
           start_red, start_green, start_blue,
    input  ready
  );
  modport sink (
    input  valid, cmd, index, target_red, target_green, target_blue,
           start_red, start_green, start_blue,
    output ready
  );
endinterface

interface plf_rsp_if import plf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [INDEX_W-1:0] entry;
  logic [COLOR_W-1:0] red;
  logic [COLOR_W-1:0] green;
  logic [COLOR_W-1:0] blue;

  modport source (
    output valid, entry, red, green, blue,
    input  ready
  );
  modport sink (
    input  valid, entry, red, green, blue,
    output ready
  );
endinterface

// ===== rtl/palette_linear_fade.sv =====
// Linear palette fade. Requests arrive on req_i (valid/ready); each request
// gives exactly one response on rsp_o (valid/ready) carrying the entry and
// its current colour. An init request loads the entry with the start colour
// and computes per-channel increments (target - start) / fade_steps; a step
// request adds the increments with saturation and reports the new colour.
// fade_steps is written through cfg_we_i/cfg_wdata_i; the user must do so only
// while idle, which the block does not enforce; a value of zero acts as one.
// After acceptance, an init runs the divider lanes in ST_DIVIDE, which produce
// one quotient bit per cycle, and then commits in ST_FINISH; a step reads the
// colour stores in ST_READ and then does the saturating add and commit in
// ST_FINISH; an entry beyond the palette goes straight to ST_FINISH and reports
// zero colour.
// One request is in progress at a time; the block is ready again in the cycle
// the response goes valid.
// Reset returns the controller to idle, clears the response valid and sets
// fade_steps to 64; the colour stores are not cleared and an entry must be
// initialised before it is stepped.
// When the receiver stalls, the result is held stable and a finished request
// waits in its last cycle until the output register is free.
// ---------------------------------------------------------------------------
// palette fade top level
// controller and datapath of the linear palette fade
// ---------------------------------------------------------------------------
module palette_linear_fade import plf_pkg::*; #(
  parameter int PALETTE_ENTRIES = 256,
  parameter int FRACTION_BITS   = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [STEPS_W-1:0] cfg_wdata_i,
  plf_req_if.sink            req_i,
  plf_rsp_if.source          rsp_o
);

  plf_ctrl_t          ctrl;
  plf_stat_t          stat;
  logic [COLOR_W-1:0] target [3];
  logic [COLOR_W-1:0] start [3];
  logic [COLOR_W-1:0] color [3];

  // request colours as per-channel arrays
  assign target[0] = req_i.target_red;
  assign target[1] = req_i.target_green;
  assign target[2] = req_i.target_blue;
  assign start[0]  = req_i.start_red;
  assign start[1]  = req_i.start_green;
  assign start[2]  = req_i.start_blue;

  plf_ctrl #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  plf_datapath #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES),
    .FRACTION_BITS   (FRACTION_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (req_i.cmd),
    .index_i     (req_i.index),
    .target_i    (target),
    .start_i     (start),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .entry_o     (rsp_o.entry),
    .color_o     (color)
  );

  // response colours
  assign rsp_o.red   = color[0];
  assign rsp_o.green = color[1];
  assign rsp_o.blue  = color[2];

endmodule

// ===== rtl/plf_div_lane.sv =====
// ---------------------------------------------------------------------------
// palette fade divider lane
// restoring divider, one quotient bit per cycle while step_i is high
// ---------------------------------------------------------------------------
module plf_div_lane import plf_pkg::*; #(
  parameter int QW = 24
) (
  input  logic               clk_i,
  input  logic               load_i,
  input  logic               step_i,
  input  logic [QW-1:0]      dividend_i,
  input  logic [STEPS_W-1:0] divisor_i,
  output logic [QW-1:0]      quotient_o
);

  logic [STEPS_W-1:0] rem_q, rem_d;
  logic [QW-1:0]      quo_q, quo_d;
  logic [STEPS_W:0]   trial;
  logic               fits;

  // shift in the next dividend bit and try the subtraction
  always_comb begin
    trial = {rem_q, quo_q[QW-1]};
    fits  = (trial >= {1'b0, divisor_i});
    rem_d = fits ? STEPS_W'(trial - {1'b0, divisor_i}) : trial[STEPS_W-1:0];
    quo_d = {quo_q[QW-2:0], fits};
  end

  // partial remainder and quotient shift register
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
    end else if (step_i) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign quotient_o = quo_q;

endmodule

// ===== rtl/plf_datapath.sv =====
// ---------------------------------------------------------------------------
// palette fade datapath
// request registers, divider lanes, colour stores and result register
// ---------------------------------------------------------------------------
module plf_datapath import plf_pkg::*; #(
  parameter int PALETTE_ENTRIES = 256,
  parameter int FRACTION_BITS   = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [STEPS_W-1:0] cfg_wdata_i,
  input  logic               cmd_i,
  input  logic [INDEX_W-1:0] index_i,
  input  logic [COLOR_W-1:0] target_i [3],
  input  logic [COLOR_W-1:0] start_i [3],
  input  plf_ctrl_t          ctrl_i,
  output plf_stat_t          stat_o,
  output logic [INDEX_W-1:0] entry_o,
  output logic [COLOR_W-1:0] color_o [3]
);

  localparam int AW     = COLOR_W + FRACTION_BITS;
  localparam int IW     = AW + 1;
  localparam int ADDR_W = $clog2(PALETTE_ENTRIES);

  logic [STEPS_W-1:0] steps_q;
  logic [STEPS_W-1:0] divisor_q;
  logic               cmd_q;
  logic               in_range_q;
  logic [INDEX_W-1:0] idx_q;
  logic [COLOR_W-1:0] start_q [3];
  logic [2:0]         neg_q;
  logic [COLOR_W-1:0] mag [3];
  logic [AW-1:0]      quotient [3];
  logic               req_in_range;

  logic [2:0][AW-1:0] acc_mem [PALETTE_ENTRIES];
  logic [2:0][IW-1:0] inc_mem [PALETTE_ENTRIES];
  logic [2:0][AW-1:0] acc_rd_q;
  logic [2:0][IW-1:0] inc_rd_q;
  logic [2:0][AW-1:0] acc_new;
  logic [2:0][IW-1:0] inc_new;
  logic [AW+1:0]      sum [3];
  logic [ADDR_W-1:0]  addr;

  // request decode for the controller
  assign req_in_range    = ({1'b0, index_i} < (INDEX_W + 1)'(PALETTE_ENTRIES));
  assign stat_o.is_step  = (cmd_i == CMD_STEP);
  assign stat_o.in_range = req_in_range;

  // fade step count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steps_q <= STEPS_RESET;
    end else if (cfg_we_i) begin
      steps_q <= cfg_wdata_i;
    end
  end

  // request capture, a step count of zero divides by one
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cmd_q      <= cmd_i;
      in_range_q <= req_in_range;
      idx_q      <= index_i;
      divisor_q  <= (steps_q == '0) ? STEPS_W'(1) : steps_q;
      for (int c = 0; c < 3; c++) begin
        start_q[c] <= start_i[c];
        neg_q[c]   <= (start_i[c] > target_i[c]);
      end
    end
  end

  // colour distance magnitudes feed the divider lanes
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      mag[c] = (start_i[c] > target_i[c]) ? COLOR_W'(start_i[c] - target_i[c])
                                          : COLOR_W'(target_i[c] - start_i[c]);
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_lane
    plf_div_lane #(
      .QW (AW)
    ) u_lane (
      .clk_i      (clk_i),
      .load_i     (ctrl_i.load),
      .step_i     (ctrl_i.div_step),
      .dividend_i ({mag[g], {FRACTION_BITS{1'b0}}}),
      .divisor_i  (ctrl_i.load ? steps_q : divisor_q),
      .quotient_o (quotient[g])
    );
  end

  assign addr = idx_q[ADDR_W-1:0];

  // new accumulator and increment values at commit
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum[c] = {2'b00, acc_rd_q[c]} + {inc_rd_q[c][IW-1], inc_rd_q[c]};
      inc_new[c] = neg_q[c] ? IW'(~{1'b0, quotient[c]} + 1'b1) : {1'b0, quotient[c]};
      if (cmd_q == CMD_STEP) begin
        // saturate the sum to the accumulator range
        priority if (sum[c][AW+1]) begin
          acc_new[c] = '0;
        end else if (sum[c][AW]) begin
          acc_new[c] = '1;
        end else begin
          acc_new[c] = sum[c][AW-1:0];
        end
      end else begin
        acc_new[c] = {start_q[c], {FRACTION_BITS{1'b0}}};
      end
    end
  end

  // accumulator store
  always_ff @(posedge clk_i) begin
    if (ctrl_i.commit && in_range_q) begin
      acc_mem[addr] <= acc_new;
    end
    if (ctrl_i.mem_read) begin
      acc_rd_q <= acc_mem[addr];
    end
  end

  // increment store, written on init only
  always_ff @(posedge clk_i) begin
    if (ctrl_i.commit && in_range_q && (cmd_q == CMD_INIT)) begin
      inc_mem[addr] <= inc_new;
    end
    if (ctrl_i.mem_read) begin
      inc_rd_q <= inc_mem[addr];
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (ctrl_i.commit) begin
      entry_o <= idx_q;
      for (int c = 0; c < 3; c++) begin
        color_o[c] <= in_range_q ? acc_new[c][AW-1:FRACTION_BITS] : '0;
      end
    end
  end

endmodule

// ===== rtl/plf_ctrl.sv =====
// ---------------------------------------------------------------------------
// palette fade controller
// sequences init and step requests and owns the handshakes
// ---------------------------------------------------------------------------
module plf_ctrl import plf_pkg::*; #(
  parameter int FRACTION_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      req_valid_i,
  output logic      req_ready_o,
  output logic      rsp_valid_o,
  input  logic      rsp_ready_i,
  input  plf_stat_t stat_i,
  output plf_ctrl_t ctrl_o
);

  localparam int DIV_BITS = COLOR_W + FRACTION_BITS;
  localparam int CNT_W    = $clog2(DIV_BITS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_BITS - 1);

  plf_state_e       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             rsp_valid_q, rsp_valid_d;

  // state, divide counter and result valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // next state and datapath commands
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    rsp_valid_d = rsp_valid_q && !rsp_ready_i;
    ctrl_o      = '0;
    req_ready_o = (state_q == ST_IDLE);
    unique case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          ctrl_o.load = 1'b1;
          cnt_d       = '0;
          priority if (!stat_i.in_range) begin
            state_d = ST_FINISH;
          end else if (stat_i.is_step) begin
            state_d = ST_READ;
          end else begin
            state_d = ST_DIVIDE;
          end
        end
      end
      ST_DIVIDE: begin
        ctrl_o.div_step = 1'b1;
        cnt_d           = CNT_W'(cnt_q + 1'b1);
        if (cnt_q == CNT_LAST) begin
          state_d = ST_FINISH;
        end
      end
      ST_READ: begin
        ctrl_o.mem_read = 1'b1;
        state_d         = ST_FINISH;
      end
      ST_FINISH: begin
        // wait here while the previous result is still held
        if (!rsp_valid_q || rsp_ready_i) begin
          ctrl_o.commit = 1'b1;
          rsp_valid_d   = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign rsp_valid_o = rsp_valid_q;

endmodule

// ===== rtl/plf_checker.sv =====
// ---------------------------------------------------------------------------
// palette fade checker
// port-level assertions bound to the palette fade top level
// ---------------------------------------------------------------------------
`include "palette_linear_fade_defines.svh"

module plf_checker import plf_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               req_valid_i,
  input logic               req_ready_i,
  input logic               rsp_valid_i,
  input logic               rsp_ready_i,
  input logic [INDEX_W-1:0] rsp_entry_i,
  input logic [COLOR_W-1:0] rsp_red_i,
  input logic [COLOR_W-1:0] rsp_green_i,
  input logic [COLOR_W-1:0] rsp_blue_i
);

  // a stalled response stays valid and unchanged
  `PLF_ASSERT_NEXT(a_rsp_hold, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i, rsp_valid_i && $stable(rsp_entry_i) && $stable(rsp_red_i) && $stable(rsp_green_i) && $stable(rsp_blue_i), "response changed while stalled")

  // one request at a time: ready drops after an accepted request
  `PLF_ASSERT_NEXT(a_one_in_flight, clk_i, rst_ni, req_valid_i && req_ready_i, !req_ready_i, "request accepted while busy")

  // no response can appear in the cycle right after acceptance
  `PLF_ASSERT_NEXT(a_min_latency, clk_i, rst_ni, req_valid_i && req_ready_i, !$rose(rsp_valid_i), "response too early")

  // reset clears the pending response
  `PLF_ASSERT_IN_RESET(a_reset_clear, clk_i, rst_ni, !rsp_valid_i, "response valid in reset")

endmodule

bind palette_linear_fade plf_checker u_plf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_entry_i (rsp_o.entry),
  .rsp_red_i   (rsp_o.red),
  .rsp_green_i (rsp_o.green),
  .rsp_blue_i  (rsp_o.blue)
);
